// ----- design/tcs_pkg.sv -----
// Shared constants, codes and structs of the toy CPU step core
package tcs_pkg;

    localparam int unsigned PROGRAM_WORDS_DEF = 32;
    localparam int unsigned DATA_WORDS_DEF    = 32;

    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned DATA_BITS = 16;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned ADDR_SPAN = 32;
    localparam int unsigned OP_BITS   = 3;
    localparam int unsigned FLAG_BITS = 3;
    localparam int unsigned RIDX_BITS = 4;

    localparam logic [RIDX_BITS-1:0] FLAG_REG  = 4'd15;
    localparam logic [FLAG_BITS-1:0] FLAG_ZERO = 3'd1;
    localparam logic [FLAG_BITS-1:0] FLAG_POS  = 3'd2;
    localparam logic [FLAG_BITS-1:0] FLAG_NEG  = 3'd4;

    // Item codes of the command word
    typedef enum logic [OP_BITS-1:0] {
        ITEM_STEP    = 3'd0,
        ITEM_WR_PROG = 3'd1,
        ITEM_WR_DATA = 3'd2,
        ITEM_RD_REG  = 3'd3,
        ITEM_RD_DATA = 3'd4
    } t_item_op;

    // Instruction opcodes
    typedef enum logic [4:0] {
        OPC_NOP    = 5'd0,
        OPC_ADD    = 5'd1,
        OPC_SUB    = 5'd2,
        OPC_AND    = 5'd3,
        OPC_OR     = 5'd4,
        OPC_XOR    = 5'd5,
        OPC_NOT    = 5'd6,
        OPC_SHL    = 5'd7,
        OPC_SHR    = 5'd8,
        OPC_LDI    = 5'd9,
        OPC_STI    = 5'd10,
        OPC_MOV    = 5'd11,
        OPC_MMOV   = 5'd12,
        OPC_ST     = 5'd13,
        OPC_LD     = 5'd14,
        OPC_LDIND  = 5'd15,
        OPC_JZ     = 5'd16,
        OPC_JP     = 5'd17,
        OPC_JN     = 5'd18,
        OPC_JMP    = 5'd19
    } t_opcode;

    // Read addresses from execute to the state store
    typedef struct packed {
        logic [RIDX_BITS-1:0] rf_a_idx;
        logic [RIDX_BITS-1:0] rf_b_idx;
        logic [ADDR_BITS-1:0] dm_idx;
    } t_rd_req;

    // Read data from the state store
    typedef struct packed {
        logic [ADDR_BITS-1:0] pc;
        logic [WORD_BITS-1:0] instr;
        logic [DATA_BITS-1:0] rf_a;
        logic [DATA_BITS-1:0] rf_b;
        logic [FLAG_BITS-1:0] flag;
        logic [DATA_BITS-1:0] dm_val;
    } t_rd_data;

    // State updates of one item
    typedef struct packed {
        logic                 pc_we;
        logic [ADDR_BITS-1:0] pc_val;
        logic                 rf_we;
        logic [RIDX_BITS-1:0] rf_idx;
        logic [DATA_BITS-1:0] rf_val;
        logic                 flag_we;
        logic [FLAG_BITS-1:0] flag_val;
        logic                 dm_we;
        logic [ADDR_BITS-1:0] dm_idx;
        logic [DATA_BITS-1:0] dm_val;
        logic                 pm_we;
        logic [ADDR_BITS-1:0] pm_idx;
        logic [WORD_BITS-1:0] pm_val;
    } t_wr_cmd;

    // Result word fields
    typedef struct packed {
        logic [ADDR_BITS-1:0] next_pc;
        logic [WORD_BITS-1:0] instr_word;
        logic [FLAG_BITS-1:0] flag_bits;
        logic [DATA_BITS-1:0] read_value;
    } t_result;

endpackage

// ----- design/tcs_if.sv -----
// Command and result channel interfaces of the toy CPU step core
interface tcs_cmd_if import tcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   op;
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] wdata;

    modport source (output valid, op, addr, wdata, input ready);
    modport sink   (input valid, op, addr, wdata, output ready);
endinterface

interface tcs_res_if import tcs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [ADDR_BITS-1:0]        next_pc;
    logic [WORD_BITS-1:0]        instr_word;
    logic [FLAG_BITS-1:0]        flag_bits;
    logic signed [DATA_BITS-1:0] read_value;

    modport source (output valid, next_pc, instr_word, flag_bits, read_value, input ready);
    modport sink   (input valid, next_pc, instr_word, flag_bits, read_value, output ready);
endinterface

// ----- design/toy_cpu_instruction_step_core.sv -----
// Top level of the toy CPU step core: input register, execute, result register
//
// Command channel i_cmd carries one word per item: op (step, write program
// word, write data word, read register, read data word), addr and wdata.
// Result channel o_res returns exactly one word per item: next_pc, the
// instruction word run by a step (else zero), the low flag bits of register
// 15 and, for read items, the value read (else zero).
// A command word is taken into the input register; once the result register
// is free or draining, it is executed against the register file and memories,
// all held in flip-flops, and the result lands in the output register. While
// the receiver takes results, throughput is one item per cycle, each item
// seeing every state change of the one before; the longest path is the
// indirect load: program word fetch, register read, data read.
// Reset clears the program counter, all registers and both memories, and
// empties both stage registers. While the receiver stalls, the
// result word holds, one more command word is still taken into the input
// register, and the command channel then stalls until the result is taken.
module toy_cpu_instruction_step_core import tcs_pkg::*; #(
    parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEF,
    parameter int unsigned DATA_WORDS    = DATA_WORDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcs_cmd_if.sink   i_cmd,
    tcs_res_if.source o_res
);

    logic                 r_in_vld;
    logic [OP_BITS-1:0]   r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [WORD_BITS-1:0] r_wdata;
    logic                 r_out_vld;
    t_result              r_res;
    logic                 n_out_vld;

    logic     w_fire;
    logic     w_take;
    t_rd_req  w_req;
    t_rd_data w_rd;
    t_wr_cmd  w_wr;
    t_wr_cmd  w_wr_gated;
    t_result  w_res;

    // Execute when an item waits and the result register is free or draining
    assign w_fire      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || w_fire;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take || w_fire) begin
            r_in_vld <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op    <= i_cmd.op;
            r_addr  <= i_cmd.addr;
            r_wdata <= i_cmd.wdata;
        end
    end

    tcs_exec #(
        .PROGRAM_WORDS (PROGRAM_WORDS),
        .DATA_WORDS    (DATA_WORDS)
    ) u_exec (
        .i_op    (r_op),
        .i_addr  (r_addr),
        .i_wdata (r_wdata),
        .i_rd    (w_rd),
        .o_req   (w_req),
        .o_wr    (w_wr),
        .o_res   (w_res)
    );

    // Drop writes unless the item executes this cycle
    assign w_wr_gated = w_fire ? w_wr : '0;

    tcs_state #(
        .PROGRAM_WORDS (PROGRAM_WORDS),
        .DATA_WORDS    (DATA_WORDS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_wr    (w_wr_gated),
        .o_rd    (w_rd)
    );

    // Result register: hold while stalled, advance on execute
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_res.ready) n_out_vld = 1'b0;
        if (w_fire) n_out_vld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.next_pc    = r_res.next_pc;
    assign o_res.instr_word = r_res.instr_word;
    assign o_res.flag_bits  = r_res.flag_bits;
    assign o_res.read_value = r_res.read_value;

    // Every executed item leaves a result word
    a_fire_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_vld
    ) else $error("executed item left no result word");

    // A stalled result blocks execution
    a_stall_blocks_exec: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |-> !w_fire
    ) else $error("item executed over a stalled result word");

    // Only read items return a read value
    a_read_value_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op != ITEM_RD_REG && r_op != ITEM_RD_DATA)
            |=> (o_res.read_value == '0)
    ) else $error("non-read item returned a read value");

    // Non-step items leave the program counter alone
    a_pc_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op != ITEM_STEP) |-> (w_res.next_pc == w_rd.pc)
    ) else $error("non-step item moved the program counter");

endmodule

// ----- design/tcs_alu.sv -----
// Arithmetic and logic unit with flag generation
module tcs_alu import tcs_pkg::*; (
    input  t_opcode              i_opc,
    input  logic [DATA_BITS-1:0] i_a,
    input  logic [DATA_BITS-1:0] i_b,
    output logic [DATA_BITS-1:0] o_result,
    output logic [FLAG_BITS-1:0] o_flag
);

    logic                 w_big_shift;
    logic [DATA_BITS-1:0] w_fill;

    assign w_big_shift = |i_b[DATA_BITS-1:RIDX_BITS];
    assign w_fill      = {DATA_BITS{i_a[DATA_BITS-1]}};

    // Compute the operation
    always_comb begin
        unique case (i_opc)
            OPC_ADD: o_result = i_a + i_b;
            OPC_SUB: o_result = i_a - i_b;
            OPC_AND: o_result = i_a & i_b;
            OPC_OR:  o_result = i_a | i_b;
            OPC_XOR: o_result = i_a ^ i_b;
            OPC_NOT: o_result = ~i_a;
            OPC_SHL: o_result = w_big_shift ? '0 : (i_a << i_b[RIDX_BITS-1:0]);
            OPC_SHR: o_result = w_big_shift ? w_fill
                              : DATA_BITS'($signed(i_a) >>> i_b[RIDX_BITS-1:0]);
            default: o_result = i_a;
        endcase
    end

    // Classify the result
    always_comb begin
        priority if (o_result == '0) o_flag = FLAG_ZERO;
        else if (o_result[DATA_BITS-1]) o_flag = FLAG_NEG;
        else o_flag = FLAG_POS;
    end

endmodule

// ----- design/tcs_state.sv -----
// Program counter, register file, data and program stores
module tcs_state import tcs_pkg::*; #(
    parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEF,
    parameter int unsigned DATA_WORDS    = DATA_WORDS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rd_req  i_req,
    input  t_wr_cmd  i_wr,
    output t_rd_data o_rd
);

    localparam int unsigned PAW = $clog2(PROGRAM_WORDS);
    localparam int unsigned DAW = $clog2(DATA_WORDS);

    logic [PAW-1:0]       r_pc;
    logic [DATA_BITS-1:0] r_rf [REG_COUNT];
    logic [DATA_BITS-1:0] r_dm [DATA_WORDS];
    logic [WORD_BITS-1:0] r_pm [PROGRAM_WORDS];

    // Clear everything at reset, else apply the item's writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            for (int i = 0; i < REG_COUNT; i++) r_rf[i] <= '0;
            for (int i = 0; i < DATA_WORDS; i++) r_dm[i] <= '0;
            for (int i = 0; i < PROGRAM_WORDS; i++) r_pm[i] <= '0;
        end else begin
            if (i_wr.pc_we) r_pc <= i_wr.pc_val[PAW-1:0];
            if (i_wr.rf_we) r_rf[i_wr.rf_idx] <= i_wr.rf_val;
            // flags land after the destination so they win on register 15
            if (i_wr.flag_we) r_rf[FLAG_REG] <= DATA_BITS'(i_wr.flag_val);
            if (i_wr.dm_we) r_dm[i_wr.dm_idx[DAW-1:0]] <= i_wr.dm_val;
            if (i_wr.pm_we) r_pm[i_wr.pm_idx[PAW-1:0]] <= i_wr.pm_val;
        end
    end

    // Read ports
    assign o_rd.pc     = ADDR_BITS'(r_pc);
    assign o_rd.instr  = r_pm[r_pc];
    assign o_rd.rf_a   = r_rf[i_req.rf_a_idx];
    assign o_rd.rf_b   = r_rf[i_req.rf_b_idx];
    assign o_rd.flag   = r_rf[FLAG_REG][FLAG_BITS-1:0];
    assign o_rd.dm_val = r_dm[i_req.dm_idx[DAW-1:0]];

endmodule

// ----- design/tcs_exec.sv -----
// Item decode and instruction execute: read addresses, state writes, result
module tcs_exec import tcs_pkg::*; #(
    parameter int unsigned PROGRAM_WORDS = PROGRAM_WORDS_DEF,
    parameter int unsigned DATA_WORDS    = DATA_WORDS_DEF
) (
    input  logic [OP_BITS-1:0]   i_op,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  t_rd_data             i_rd,
    output t_rd_req              o_req,
    output t_wr_cmd              o_wr,
    output t_result              o_res
);

    logic [ADDR_BITS-1:0] w_prog_mod [ADDR_SPAN];
    logic [ADDR_BITS-1:0] w_data_mod [ADDR_SPAN];
    t_opcode              w_opc;
    logic [DATA_BITS-1:0] w_lit;
    logic [ADDR_BITS-1:0] w_opa;
    logic [ADDR_BITS-1:0] w_opb;
    logic [ADDR_BITS-1:0] w_pc_inc;
    logic [DATA_BITS-1:0] w_alu_res;
    logic [FLAG_BITS-1:0] w_alu_flag;

    // Wrap tables for program and data addresses
    for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_mod
        localparam int unsigned ProgVal = g % PROGRAM_WORDS;
        localparam int unsigned DataVal = g % DATA_WORDS;
        assign w_prog_mod[g] = ADDR_BITS'(ProgVal);
        assign w_data_mod[g] = ADDR_BITS'(DataVal);
    end

    // Split the instruction word; the literal keeps its low 16 bits
    assign w_opc = t_opcode'(i_rd.instr[31:27]);
    assign w_lit = i_rd.instr[25:10];
    assign w_opa = i_rd.instr[9:5];
    assign w_opb = i_rd.instr[4:0];

    assign w_pc_inc = (i_rd.pc == ADDR_BITS'(PROGRAM_WORDS - 1))
                    ? '0 : i_rd.pc + ADDR_BITS'(1);

    tcs_alu u_alu (
        .i_opc    (w_opc),
        .i_a      (i_rd.rf_a),
        .i_b      (i_rd.rf_b),
        .o_result (w_alu_res),
        .o_flag   (w_alu_flag)
    );

    // Decode the item and build reads, writes and the result word
    always_comb begin
        o_req.rf_a_idx    = w_opa[RIDX_BITS-1:0];
        o_req.rf_b_idx    = w_opb[RIDX_BITS-1:0];
        o_req.dm_idx      = w_data_mod[w_opb];
        o_wr              = '0;
        o_res.instr_word  = '0;
        o_res.read_value  = '0;

        unique case (t_item_op'(i_op))
            ITEM_STEP: begin
                o_res.instr_word = i_rd.instr;
                o_wr.pc_we       = 1'b1;
                o_wr.pc_val      = w_pc_inc;
                o_wr.rf_idx      = w_opa[RIDX_BITS-1:0];
                o_wr.dm_idx      = w_data_mod[w_opa];
                unique case (w_opc)
                    OPC_ADD, OPC_SUB, OPC_AND, OPC_OR,
                    OPC_XOR, OPC_NOT, OPC_SHL, OPC_SHR: begin
                        o_wr.rf_we    = 1'b1;
                        o_wr.rf_val   = w_alu_res;
                        o_wr.flag_we  = 1'b1;
                        o_wr.flag_val = w_alu_flag;
                    end
                    OPC_LDI: begin
                        o_wr.rf_we  = 1'b1;
                        o_wr.rf_val = w_lit;
                    end
                    OPC_STI: begin
                        o_wr.dm_we  = 1'b1;
                        o_wr.dm_val = w_lit;
                    end
                    OPC_MOV: begin
                        o_wr.rf_we  = 1'b1;
                        o_wr.rf_val = i_rd.rf_b;
                    end
                    OPC_MMOV: begin
                        o_wr.dm_we  = 1'b1;
                        o_wr.dm_val = i_rd.dm_val;
                    end
                    OPC_ST: begin
                        o_wr.dm_we  = 1'b1;
                        o_wr.dm_val = i_rd.rf_b;
                    end
                    OPC_LD: begin
                        o_wr.rf_we  = 1'b1;
                        o_wr.rf_val = i_rd.dm_val;
                    end
                    OPC_LDIND: begin
                        o_req.dm_idx = w_data_mod[i_rd.rf_b[ADDR_BITS-1:0]];
                        o_wr.rf_we   = 1'b1;
                        o_wr.rf_val  = i_rd.dm_val;
                    end
                    OPC_JZ: if ((i_rd.flag & FLAG_ZERO) != '0) o_wr.pc_val = w_prog_mod[w_opa];
                    OPC_JP: if ((i_rd.flag & FLAG_POS) != '0) o_wr.pc_val = w_prog_mod[w_opa];
                    OPC_JN: if ((i_rd.flag & FLAG_NEG) != '0) o_wr.pc_val = w_prog_mod[w_opa];
                    OPC_JMP: o_wr.pc_val = w_prog_mod[w_opa];
                    default: ;
                endcase
            end
            ITEM_WR_PROG: begin
                o_wr.pm_we  = 1'b1;
                o_wr.pm_idx = w_prog_mod[i_addr];
                o_wr.pm_val = i_wdata;
            end
            ITEM_WR_DATA: begin
                o_wr.dm_we  = 1'b1;
                o_wr.dm_idx = w_data_mod[i_addr];
                o_wr.dm_val = i_wdata[DATA_BITS-1:0];
            end
            ITEM_RD_REG: begin
                o_req.rf_a_idx   = i_addr[RIDX_BITS-1:0];
                o_res.read_value = i_rd.rf_a;
            end
            ITEM_RD_DATA: begin
                o_req.dm_idx     = w_data_mod[i_addr];
                o_res.read_value = i_rd.dm_val;
            end
            default: ;
        endcase

        // Report state as it stands after this item
        priority if (o_wr.flag_we) o_res.flag_bits = o_wr.flag_val;
        else if (o_wr.rf_we && o_wr.rf_idx == FLAG_REG)
            o_res.flag_bits = o_wr.rf_val[FLAG_BITS-1:0];
        else o_res.flag_bits = i_rd.flag;

        o_res.next_pc = o_wr.pc_we ? o_wr.pc_val : i_rd.pc;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the toy CPU step core: directed and random stimulus against a scoreboard
`timescale 1ns / 100ps

module testbench;
    import tcs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_CYCLES  = 10;

    // Item codes and opcodes that the block treats as no-ops
    localparam logic [OP_BITS-1:0] ITEM_SPARE_FIRST = 3'd5;
    localparam logic [OP_BITS-1:0] ITEM_SPARE_LAST  = 3'd7;
    localparam logic [4:0]         OPC_SPARE_FIRST  = 5'd20;
    localparam logic [4:0]         OPC_SPARE_LAST   = 5'd31;

    // Predict the result word of each accepted command word and check it
    class cpu_result_board;
        logic [ADDR_BITS-1:0] pc;
        logic [DATA_BITS-1:0] regs [REG_COUNT];
        logic [DATA_BITS-1:0] dmem [ADDR_SPAN];
        logic [WORD_BITS-1:0] pmem [ADDR_SPAN];
        t_result              pending_results [$];
        int                   errors;

        function new();
            pc = '0;
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            foreach (pmem[i]) pmem[i] = '0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Run one command word against the shadow state
        function void execute_item(logic [OP_BITS-1:0] op, logic [ADDR_BITS-1:0] addr,
                                   logic [WORD_BITS-1:0] wdata);
            logic [WORD_BITS-1:0] word;
            logic [4:0]           opc;
            logic [16:0]          lit;
            logic [4:0]           opa;
            logic [4:0]           opb;
            logic [RIDX_BITS-1:0] ra;
            logic [RIDX_BITS-1:0] rb;
            logic [DATA_BITS-1:0] a;
            logic [DATA_BITS-1:0] b;
            logic [DATA_BITS-1:0] r;
            logic [FLAG_BITS-1:0] flags;
            logic [ADDR_BITS-1:0] next_pc;
            logic [DATA_BITS-1:0] rd;
            t_result              res;

            word = '0;
            rd   = '0;
            case (op)
                ITEM_STEP: begin
                    word    = pmem[pc];
                    opc     = word[31:27];
                    lit     = word[26:10];
                    opa     = word[9:5];
                    opb     = word[4:0];
                    ra      = opa[RIDX_BITS-1:0];
                    rb      = opb[RIDX_BITS-1:0];
                    a       = regs[ra];
                    b       = regs[rb];
                    flags   = regs[FLAG_REG][FLAG_BITS-1:0];
                    next_pc = pc + 1'b1;
                    if (opc >= OPC_ADD && opc <= OPC_SHR) begin
                        case (opc)
                            OPC_ADD: r = a + b;
                            OPC_SUB: r = a - b;
                            OPC_AND: r = a & b;
                            OPC_OR:  r = a | b;
                            OPC_XOR: r = a ^ b;
                            OPC_NOT: r = ~a;
                            OPC_SHL: r = (b >= DATA_BITS) ? '0 : a << b[3:0];
                            default: r = (b >= DATA_BITS) ? {DATA_BITS{a[15]}}
                                                          : $unsigned($signed(a) >>> b[3:0]);
                        endcase
                        regs[ra] = r;
                        // Flag register takes the sign class of the ALU result
                        if (r == '0)
                            regs[FLAG_REG] = DATA_BITS'(FLAG_ZERO);
                        else if (r[15])
                            regs[FLAG_REG] = DATA_BITS'(FLAG_NEG);
                        else
                            regs[FLAG_REG] = DATA_BITS'(FLAG_POS);
                    end else begin
                        case (opc)
                            OPC_LDI:   regs[ra]  = lit[15:0];
                            OPC_STI:   dmem[opa] = lit[15:0];
                            OPC_MOV:   regs[ra]  = b;
                            OPC_MMOV:  dmem[opa] = dmem[opb];
                            OPC_ST:    dmem[opa] = b;
                            OPC_LD:    regs[ra]  = dmem[opb];
                            OPC_LDIND: regs[ra]  = dmem[b[4:0]];
                            OPC_JZ:    if ((flags & FLAG_ZERO) != '0) next_pc = opa;
                            OPC_JP:    if ((flags & FLAG_POS) != '0) next_pc = opa;
                            OPC_JN:    if ((flags & FLAG_NEG) != '0) next_pc = opa;
                            OPC_JMP:   next_pc = opa;
                            default: ;
                        endcase
                    end
                    pc = next_pc;
                end
                ITEM_WR_PROG: pmem[addr] = wdata;
                ITEM_WR_DATA: dmem[addr] = wdata[15:0];
                ITEM_RD_REG:  rd = regs[addr[RIDX_BITS-1:0]];
                ITEM_RD_DATA: rd = dmem[addr];
                default: ;
            endcase

            res.next_pc    = pc;
            res.instr_word = word;
            res.flag_bits  = regs[FLAG_REG][FLAG_BITS-1:0];
            res.read_value = rd;
            pending_results.push_back(res);
        endfunction

        // Compare one result word with the oldest prediction
        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.next_pc !== want.next_pc || got.instr_word !== want.instr_word ||
                    got.flag_bits !== want.flag_bits || got.read_value !== want.read_value)
                    report_mismatch($sformatf(
                        "pc %0d/%0d instr %h/%h flags %0d/%0d read %h/%h (got/want)",
                        got.next_pc, want.next_pc, got.instr_word, want.instr_word,
                        got.flag_bits, want.flag_bits, got.read_value, want.read_value));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcs_cmd_if cmd_ch ();
    tcs_res_if res_ch ();

    cpu_result_board board = new();

    bit calm;
    bit hold_req;
    int cycles;

    toy_cpu_instruction_step_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Pick an idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [WORD_BITS-1:0] make_instr(logic [4:0] opc, logic [16:0] lit,
                                                        logic [4:0] opa, logic [4:0] opb);
        return {opc, lit, opa, opb};
    endfunction

    // Offer one command word, wait for acceptance, then idle at random
    task automatic push_cmd(logic [OP_BITS-1:0] op, logic [ADDR_BITS-1:0] addr,
                            logic [WORD_BITS-1:0] wdata);
        int gap;
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.addr  <= addr;
        cmd_ch.wdata <= wdata;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        board.execute_item(op, addr, wdata);
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drive ready: random stalls plus the requested long hold-off
    initial begin : result_sink
        int stall_left;
        int r;
        t_result got;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else if (calm) begin
                res_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    res_ch.ready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    res_ch.ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(9, 39);
                    res_ch.ready <= 1'b0;
                end
            end
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got.next_pc    = res_ch.next_pc;
                got.instr_word = res_ch.instr_word;
                got.flag_bits  = res_ch.flag_bits;
                got.read_value = res_ch.read_value;
                board.check_result(got);
            end
        end
    end

    // Bound the run
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        int n_items;
        int next_hold_at;
        int r;
        int len;
        logic [4:0]  opc;
        logic [16:0] lit;

        calm     = 1'b0;
        hold_req = 1'b0;
        i_rst_n      <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.op    <= ITEM_STEP;
        cmd_ch.addr  <= '0;
        cmd_ch.wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed program: literal truncation, shift extremes, taken jump,
        // register alias through operand bit 4, indirect load, PC wrap
        push_cmd(ITEM_WR_PROG, 5'd0,  make_instr(OPC_LDI, 17'h1FFFF, 5'd1, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd1,  make_instr(OPC_LDI, 17'd16, 5'd2, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd2,  make_instr(OPC_SHR, 17'd0, 5'd1, 5'd2));
        push_cmd(ITEM_WR_PROG, 5'd3,  make_instr(OPC_SHL, 17'd0, 5'd1, 5'd2));
        push_cmd(ITEM_WR_PROG, 5'd4,  make_instr(OPC_JZ, 17'd0, 5'd6, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd5,  make_instr(OPC_NOT, 17'd0, 5'd1, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd6,  make_instr(OPC_LDI, 17'h08000, 5'd17, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd7,  make_instr(OPC_ST, 17'd0, 5'd31, 5'd1));
        push_cmd(ITEM_WR_PROG, 5'd8,  make_instr(OPC_LDI, 17'h1FFFF, 5'd4, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd9,  make_instr(OPC_LDIND, 17'd0, 5'd3, 5'd4));
        push_cmd(ITEM_WR_PROG, 5'd10, make_instr(OPC_JMP, 17'd0, 5'd31, 5'd0));
        push_cmd(ITEM_WR_PROG, 5'd31, make_instr(OPC_SPARE_LAST, 17'h1FFFF, 5'd31, 5'd31));
        push_cmd(ITEM_WR_DATA, 5'd0, 32'hFFFF_8000);
        push_cmd(ITEM_RD_DATA, 5'd0, '0);
        repeat (11) push_cmd(ITEM_STEP, 5'd31, 32'hFFFF_FFFF);
        push_cmd(ITEM_RD_REG, 5'd31, '0);
        push_cmd(ITEM_SPARE_LAST, 5'd31, 32'hFFFF_FFFF);

        // Random episodes: program loads, data loads and runs of steps, reads and spare items
        n_items = 0;
        next_hold_at = 300;
        while (n_items < RANDOM_ITEMS) begin
            if (n_items >= next_hold_at) begin
                hold_req = 1'b1;
                next_hold_at += 1100;
            end
            calm = (n_items >= 700 && n_items < 900);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        opc = 5'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST));
                    else if (r < 25)
                        opc = OPC_LDI;
                    else
                        opc = 5'($urandom_range(OPC_NOP, OPC_JMP));
                    // Small literals give short shift counts and near addresses
                    lit = ($urandom_range(0, 2) == 0) ? 17'($urandom_range(0, 20))
                                                      : 17'($urandom);
                    push_cmd(ITEM_WR_PROG, 5'($urandom),
                             make_instr(opc, lit, 5'($urandom), 5'($urandom)));
                    n_items++;
                end
            end else if (r < 25) begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    push_cmd(ITEM_WR_DATA, 5'($urandom), $urandom);
                    n_items++;
                end
            end else begin
                len = $urandom_range(4, 20);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 80) begin
                        push_cmd(ITEM_STEP, 5'($urandom), $urandom);
                        n_items++;
                    end else if (r < 90) begin
                        push_cmd(ITEM_RD_REG, 5'($urandom), $urandom);
                        n_items++;
                    end else if (r < 97) begin
                        push_cmd(ITEM_RD_DATA, 5'($urandom), $urandom);
                        n_items++;
                    end else begin
                        push_cmd(3'($urandom_range(ITEM_SPARE_FIRST, ITEM_SPARE_LAST)),
                                 5'($urandom), $urandom);
                    end
                end
            end
        end
        calm = 1'b0;
        cmd_ch.valid <= 1'b0;

        // Drain the pipeline, then give stray words time to show up
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tcs_pkg.sv
design/tcs_if.sv
design/tcs_alu.sv
design/tcs_state.sv
design/tcs_exec.sv
design/toy_cpu_instruction_step_core.sv
tb/sv/testbench.sv
